### sv/four_level_page_table_engine_unit_defines.svh
// Assertion macros for the page table engine
`ifndef FOUR_LEVEL_PAGE_TABLE_ENGINE_UNIT_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FLPTE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FLPTE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/flpte_pkg.sv
// Shared types and constants of the page table engine
package flpte_pkg;

   localparam int POOL_PAGES_DEF    = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = 9;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_WRITE   = 1;
   localparam int BIT_PS      = 7;

   typedef enum logic [1:0] {
      REQ_MAP_4K = 2'd0,
      REQ_MAP_2M = 2'd1,
      REQ_XLATE  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPTR = 2'd2,
      ST_MISS   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_PAGE, S_RD, S_EV, S_CLR, S_LINK, S_LEAF, S_DONE
   } walk_state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] phys_out;
      logic [31:0] small_pages_count;
      logic [31:0] huge_pages_count;
      logic [6:0]  pool_pages_used;
   } result_type;

endpackage

### sv/flpte_if.sv
// Request and response channel interfaces
interface flpte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] virt_addr;
   logic [51:0] phys_addr;
   logic [39:0] size_bytes;
   logic [63:0] entry_flags;
   modport source (output valid, req_type, virt_addr, phys_addr, size_bytes, entry_flags,
                   input ready);
   modport sink (input valid, req_type, virt_addr, phys_addr, size_bytes, entry_flags,
                 output ready);
endinterface

interface flpte_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] phys_out;
   logic [31:0] small_pages_count;
   logic [31:0] huge_pages_count;
   logic [6:0]  pool_pages_used;
   modport source (output valid, status, phys_out, small_pages_count, huge_pages_count,
                   pool_pages_used, input ready);
   modport sink (input valid, status, phys_out, small_pages_count, huge_pages_count,
                 pool_pages_used, output ready);
endinterface

### sv/flpte_mem.sv
// Table store: single port synchronous RAM, registered read data
module flpte_mem #(
   parameter int ADDR_W = 15
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [63:0]       wdata,
   output logic [63:0]       rdata
);

   logic [63:0] mem [2**ADDR_W];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/flpte_walk.sv
// Walk sequencer: map and translate through the table store
module flpte_walk #(
   parameter int POOL_PAGES = flpte_pkg::POOL_PAGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [51:0]            pool_base,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [63:0]            virt_addr,
   input  logic [51:0]            phys_addr,
   input  logic [39:0]            size_bytes,
   input  logic [63:0]            entry_flags,
   output logic                   res_valid,
   input  logic                   res_ready,
   output flpte_pkg::result_type  res,
   output logic                   mem_we,
   output logic [$clog2(POOL_PAGES)+flpte_pkg::IDX_W-1:0] mem_addr,
   output logic [63:0]            mem_wdata,
   input  logic [63:0]            mem_rdata
);

   localparam int PG_W   = $clog2(POOL_PAGES);
   localparam int IDX_W  = flpte_pkg::IDX_W;
   localparam int ADDR_W = PG_W + IDX_W;
   localparam int CNT_W  = $clog2(POOL_PAGES + 1);

   flpte_pkg::walk_state_type state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [63:0]       va_ff, va_in;
   logic [39:0]       pa_ff, pa_in;
   logic [63:0]       end_ff, end_in;
   logic [63:0]       flags_ff, flags_in;
   logic [1:0]        lvl_ff, lvl_in;
   logic [PG_W-1:0]   page_ff, page_in;
   logic [PG_W-1:0]   newpg_ff, newpg_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  alloc_ff, alloc_in;
   logic [31:0]       small_ff, small_in;
   logic [31:0]       huge_ff, huge_in;
   logic [1:0]        st_ff, st_in;
   logic [63:0]       phys_ff, phys_in;

   logic              huge;
   logic [IDX_W-1:0]  idx;
   logic [39:0]       base_fr, ent_fr, diff;
   logic              bad_ptr, present, ps;
   logic [64:0]       va_next;
   logic [39:0]       pa_step;
   logic [1:0]        leaf_lvl;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flpte_pkg::S_INIT;
         clr_ff   <= '0;
         alloc_ff <= CNT_W'(1);
         small_ff <= '0;
         huge_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         alloc_ff <= alloc_in;
         small_ff <= small_in;
         huge_ff  <= huge_in;
      end
      kind_ff  <= kind_in;
      va_ff    <= va_in;
      pa_ff    <= pa_in;
      end_ff   <= end_in;
      flags_ff <= flags_in;
      lvl_ff   <= lvl_in;
      page_ff  <= page_in;
      newpg_ff <= newpg_in;
      st_ff    <= st_in;
      phys_ff  <= phys_in;
   end

   assign huge     = (kind_ff == flpte_pkg::REQ_MAP_2M);
   assign leaf_lvl = huge ? 2'd2 : 2'd3;
   assign base_fr  = pool_base[51:12];
   assign ent_fr   = mem_rdata[51:12];
   assign diff     = ent_fr - base_fr;
   assign bad_ptr  = (ent_fr < base_fr) || (diff >= 40'(POOL_PAGES));
   assign present  = mem_rdata[flpte_pkg::BIT_PRESENT];
   assign ps       = mem_rdata[flpte_pkg::BIT_PS];
   assign va_next  = {1'b0, va_ff} + (huge ? 65'h20_0000 : 65'h1000);
   assign pa_step  = pa_ff + (huge ? 40'd512 : 40'd1);

   always_comb begin
      case (lvl_ff)
         2'd0:    idx = va_ff[47:39];
         2'd1:    idx = va_ff[38:30];
         2'd2:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      va_in     = va_ff;
      pa_in     = pa_ff;
      end_in    = end_ff;
      flags_in  = flags_ff;
      lvl_in    = lvl_ff;
      page_in   = page_ff;
      newpg_in  = newpg_ff;
      clr_in    = clr_ff;
      alloc_in  = alloc_ff;
      small_in  = small_ff;
      huge_in   = huge_ff;
      st_in     = st_ff;
      phys_in   = phys_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = {page_ff, idx};
      mem_wdata = '0;
      unique case (state_ff)
         flpte_pkg::S_INIT: begin
            // clear the whole store after reset
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = flpte_pkg::S_IDLE;
            end
         end
         flpte_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_type;
               flags_in = entry_flags;
               end_in   = virt_addr + {24'd0, size_bytes};
               lvl_in   = 2'd0;
               page_in  = '0;
               st_in    = flpte_pkg::ST_OK;
               phys_in  = '0;
               unique case (req_type)
                  flpte_pkg::REQ_MAP_4K: begin
                     va_in    = {virt_addr[63:12], 12'd0};
                     pa_in    = phys_addr[51:12];
                     state_in = flpte_pkg::S_PAGE;
                  end
                  flpte_pkg::REQ_MAP_2M: begin
                     va_in    = {virt_addr[63:21], 21'd0};
                     pa_in    = {phys_addr[51:21], 9'd0};
                     state_in = flpte_pkg::S_PAGE;
                  end
                  flpte_pkg::REQ_XLATE: begin
                     va_in    = virt_addr;
                     phys_in  = '1;
                     state_in = flpte_pkg::S_RD;
                  end
                  default: begin
                     state_in = flpte_pkg::S_DONE;
                  end
               endcase
            end
         end
         flpte_pkg::S_PAGE: begin
            lvl_in  = 2'd0;
            page_in = '0;
            if (va_ff < end_ff) begin
               state_in = flpte_pkg::S_RD;
            end else begin
               state_in = flpte_pkg::S_DONE;
            end
         end
         flpte_pkg::S_RD: begin
            if (kind_ff != flpte_pkg::REQ_XLATE && lvl_ff == leaf_lvl) begin
               state_in = flpte_pkg::S_LEAF;
            end else begin
               state_in = flpte_pkg::S_EV;
            end
         end
         flpte_pkg::S_EV: begin
            if (kind_ff == flpte_pkg::REQ_XLATE) begin
               if (!present) begin
                  st_in    = flpte_pkg::ST_MISS;
                  state_in = flpte_pkg::S_DONE;
               end else if (lvl_ff == 2'd1 && ps) begin
                  phys_in  = {12'd0, mem_rdata[51:30], va_ff[29:0]};
                  state_in = flpte_pkg::S_DONE;
               end else if (lvl_ff == 2'd2 && ps) begin
                  phys_in  = {12'd0, mem_rdata[51:21], va_ff[20:0]};
                  state_in = flpte_pkg::S_DONE;
               end else if (lvl_ff == 2'd3) begin
                  phys_in  = {12'd0, mem_rdata[51:12], va_ff[11:0]};
                  state_in = flpte_pkg::S_DONE;
               end else if (bad_ptr) begin
                  st_in    = flpte_pkg::ST_BADPTR;
                  state_in = flpte_pkg::S_DONE;
               end else begin
                  page_in  = diff[PG_W-1:0];
                  lvl_in   = lvl_ff + 2'd1;
                  state_in = flpte_pkg::S_RD;
               end
            end else if (present) begin
               // any present upper entry is followed as a table pointer
               if (bad_ptr) begin
                  st_in    = flpte_pkg::ST_BADPTR;
                  state_in = flpte_pkg::S_DONE;
               end else begin
                  page_in  = diff[PG_W-1:0];
                  lvl_in   = lvl_ff + 2'd1;
                  state_in = flpte_pkg::S_RD;
               end
            end else if (alloc_ff >= CNT_W'(POOL_PAGES)) begin
               st_in    = flpte_pkg::ST_FULL;
               state_in = flpte_pkg::S_DONE;
            end else begin
               newpg_in = alloc_ff[PG_W-1:0];
               alloc_in = alloc_ff + 1'b1;
               clr_in   = '0;
               state_in = flpte_pkg::S_CLR;
            end
         end
         flpte_pkg::S_CLR: begin
            // zero the new table before linking it in
            mem_we   = 1'b1;
            mem_addr = {newpg_ff, clr_ff[IDX_W-1:0]};
            clr_in   = clr_ff + 1'b1;
            if (&clr_ff[IDX_W-1:0]) begin
               state_in = flpte_pkg::S_LINK;
            end
         end
         flpte_pkg::S_LINK: begin
            mem_we    = 1'b1;
            mem_wdata = {12'd0, base_fr + 40'(newpg_ff), 12'd0};
            mem_wdata[flpte_pkg::BIT_PRESENT] = 1'b1;
            mem_wdata[flpte_pkg::BIT_WRITE]   = 1'b1;
            page_in   = newpg_ff;
            lvl_in    = lvl_ff + 2'd1;
            state_in  = flpte_pkg::S_RD;
         end
         flpte_pkg::S_LEAF: begin
            mem_we    = 1'b1;
            mem_wdata = {12'd0, pa_ff, 12'd0} | flags_ff;
            mem_wdata[flpte_pkg::BIT_PRESENT] = 1'b1;
            if (huge) begin
               mem_wdata[flpte_pkg::BIT_PS] = 1'b1;
               if (huge_ff != '1) begin
                  huge_in = huge_ff + 32'd1;
               end
            end else if (small_ff != '1) begin
               small_in = small_ff + 32'd1;
            end
            pa_in = pa_step;
            va_in = va_next[63:0];
            if (va_next[64]) begin
               state_in = flpte_pkg::S_DONE;
            end else begin
               state_in = flpte_pkg::S_PAGE;
            end
         end
         flpte_pkg::S_DONE: begin
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = flpte_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = flpte_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status            = st_ff;
      res.phys_out          = phys_ff;
      res.small_pages_count = small_ff;
      res.huge_pages_count  = huge_ff;
      res.pool_pages_used   = 7'(alloc_ff);
   end

endmodule

### sv/four_level_page_table_engine_unit.sv
// Top level of the four-level page table engine
//
//  port      dir   beat content
//  req_chan  in    req_type, virt_addr, phys_addr, size_bytes, entry_flags
//  rsp_chan  out   status, phys_out, page totals, pool pages used
//  csr_*     in    pool_base_addr write
//
// After reset the store is swept clear, with req_chan.ready low. Translate walks
// the levels one read at a time on the one RAM port. Map writes a leaf entry for
// each 4 KiB or 2 MiB page; each new table is cleared before it is linked. A finished
// beat waits in the output register while the next request runs.
`include "four_level_page_table_engine_unit_defines.svh"

module four_level_page_table_engine_unit #(
   parameter int POOL_PAGES = flpte_pkg::POOL_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   flpte_req_if.sink   req_chan,
   flpte_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [51:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(POOL_PAGES) + flpte_pkg::IDX_W;

   logic [51:0]           base_ff;
   logic                  rsp_valid_ff;
   flpte_pkg::result_type rsp_ff;
   flpte_pkg::result_type res;
   logic                  res_valid, res_ready;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_addr;
   logic [63:0]           mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         if (res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   flpte_walk #(.POOL_PAGES(POOL_PAGES)) u_walk (
      .clock       (clock),
      .reset       (reset),
      .pool_base   (base_ff),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_type    (req_chan.req_type),
      .virt_addr   (req_chan.virt_addr),
      .phys_addr   (req_chan.phys_addr),
      .size_bytes  (req_chan.size_bytes),
      .entry_flags (req_chan.entry_flags),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_we      (mem_we),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .mem_rdata   (mem_rdata)
   );

   flpte_mem #(.ADDR_W(ADDR_W)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_ff.status;
   assign rsp_chan.phys_out          = rsp_ff.phys_out;
   assign rsp_chan.small_pages_count = rsp_ff.small_pages_count;
   assign rsp_chan.huge_pages_count  = rsp_ff.huge_pages_count;
   assign rsp_chan.pool_pages_used   = rsp_ff.pool_pages_used;

   `FLPTE_ASSERT_NEXT(a_no_instant_rsp, req_chan.valid && req_chan.ready && !rsp_valid_ff, !rsp_chan.valid, "response beat too early")
   `FLPTE_ASSERT_NOW(a_miss_all_ones, rsp_valid_ff && rsp_ff.status == flpte_pkg::ST_MISS, rsp_ff.phys_out == '1, "miss without all ones")
   `FLPTE_ASSERT_NOW(a_no_write_idle, req_chan.ready, !mem_we, "store written while idle")

endmodule
